// File: sv/order_crossover_engine_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the order crossover engine
// Shared assertion forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef ORDER_CROSSOVER_ENGINE_TOP_MACROS_SVH
`define ORDER_CROSSOVER_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("order crossover engine check failed");

// Next-cycle implication, disabled during reset.
`define OCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("order crossover engine check failed");

`endif

// File: sv/oce_pkg.sv
// ---------------------------------------------------------------------------
// Order crossover engine package
// Field widths, register indexes, state types and twister helper functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package oce_pkg;

	localparam int KEY_W  = 6;
	localparam int ROT_W  = 16;
	localparam int GENE_W = KEY_W + ROT_W;
	localparam int POS_W  = 6;
	localparam int KEY_SPACE = 1 << KEY_W;
	localparam int CFG_W  = 32;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [ROT_W-1:0]  rot_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CFG_W-1:0]  cfg_data_t;
	typedef logic [0:0]        cfg_index_t;

	localparam cfg_index_t REG_GENE_COUNT = 1'b0;
	localparam cfg_index_t REG_SEED       = 1'b1;

	localparam logic [6:0]  GENE_COUNT_RST = 7'd1;
	localparam logic [31:0] SEED_RST       = 32'd5489;

	localparam logic [31:0] MT_MULT   = 32'd1812433253;
	localparam logic [31:0] MT_MATRIX = 32'h9908b0df;
	localparam logic [8:0]  MT_LAST   = 9'd398;
	localparam logic [8:0]  MT_M_IDX  = 9'd397;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_DIV1,
		ST_DIV2,
		ST_COPY,
		ST_FILL_RD,
		ST_FILL_CHK,
		ST_FILL_SEEK,
		ST_EMIT,
		ST_WRAP
	} oce_state_t;

	typedef enum logic [1:0] {
		MT_IDLE,
		MT_RUN,
		MT_DONE
	} mt_state_t;

	function automatic logic [31:0] mt_regen(input logic [31:0] cur, input logic [31:0] nxt,
		input logic [31:0] far);
		logic [31:0] y;
		logic [31:0] v;
		begin
			y = {cur[31], nxt[30:0]};
			v = far ^ (y >> 1);
			if (y[0]) begin
				v = v ^ MT_MATRIX;
			end
			return v;
		end
	endfunction

	function automatic logic [31:0] mt_temper(input logic [31:0] x);
		logic [31:0] y;
		begin
			y = x;
			y = y ^ (y >> 11);
			y = y ^ ((y << 7) & 32'h9d2c5680);
			y = y ^ ((y << 15) & 32'hefc60000);
			y = y ^ (y >> 18);
			return y;
		end
	endfunction

endpackage

// File: sv/oce_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module oce_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/oce_twister.sv
// ---------------------------------------------------------------------------
// Twister cut-point generator
// Runs the seeding recurrence through one multiplier and returns the first
// two tempered outputs of the regenerated state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module oce_twister (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] seed,
	output logic        done,
	output logic [31:0] r1,
	output logic [31:0] r2
);

	import oce_pkg::*;

	mt_state_t   state_q, state_nx;
	logic [8:0]  i_q;
	logic [31:0] p_q;
	logic [31:0] s0_q, s1_q, s2_q, s397_q, s398_q;
	logic [31:0] mix;
	logic [31:0] prod;
	logic        run;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			MT_IDLE: begin
				if (start) begin
					state_nx = MT_RUN;
				end
			end
			MT_RUN: begin
				if (i_q == MT_LAST) begin
					state_nx = MT_DONE;
				end
			end
			MT_DONE: state_nx = MT_IDLE;
			default: state_nx = MT_IDLE;
		endcase
	end

	always_comb begin
		run  = 1'b0;
		done = 1'b0;
		unique case (state_q)
			MT_IDLE: ;
			MT_RUN:  run = 1'b1;
			MT_DONE: done = 1'b1;
			default: ;
		endcase
	end

	assign mix  = p_q ^ (p_q >> 30);
	assign prod = MT_MULT * mix + {23'd0, i_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MT_IDLE;
			i_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (start && state_q == MT_IDLE) begin
				i_q <= 9'd1;
			end else if (run) begin
				i_q <= i_q + 9'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == MT_IDLE) begin
			p_q  <= seed;
			s0_q <= seed;
		end else if (run) begin
			p_q <= prod;
			if (i_q == 9'd1) begin
				s1_q <= prod;
			end
			if (i_q == 9'd2) begin
				s2_q <= prod;
			end
			if (i_q == MT_M_IDX) begin
				s397_q <= prod;
			end
			if (i_q == MT_LAST) begin
				s398_q <= prod;
			end
		end
	end

	assign r1 = mt_temper(mt_regen(s0_q, s1_q, s397_q));
	assign r2 = mt_temper(mt_regen(s1_q, s2_q, s398_q));

endmodule

// File: sv/order_crossover_engine_top.sv
// ---------------------------------------------------------------------------
// Order crossover engine
// Loads two parent permutations, picks two cut points from a seeded twister,
// builds the order crossover child and streams out every child slot.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// config    in         cfg_we                  cfg_index, cfg_data
// gene      in         start while busy low    kind, gene_key, rotation_code
// result    out        result_strobe           position, child_key,
//                                              child_rotation, slot_filled, last
//
// The beat that completes both parents starts a job, most of it the 398-step
// seeding recurrence through the twister's single multiplier; busy is high
// throughout.
// arst_n clears all control state; stores hold no reset contents.
// Results come one per cycle and cannot be stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "order_crossover_engine_top_macros.svh"

module order_crossover_engine_top #(
	parameter int GENE_SLOTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 kind,
	input  oce_pkg::key_t        gene_key,
	input  oce_pkg::rot_t        rotation_code,
	input  logic                 cfg_we,
	input  oce_pkg::cfg_index_t  cfg_index,
	input  oce_pkg::cfg_data_t   cfg_data,
	output logic                 result_strobe,
	output oce_pkg::pos_t        position,
	output oce_pkg::key_t        child_key,
	output oce_pkg::rot_t        child_rotation,
	output logic                 slot_filled,
	output logic                 last
);

	import oce_pkg::*;

	localparam int ADDR_W = (GENE_SLOTS > 1) ? $clog2(GENE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(GENE_SLOTS + 1);
	localparam int REM_W  = CNT_W + 1;
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(GENE_SLOTS);

	oce_state_t         state_q, state_nx;
	logic [6:0]         gene_count_q;
	logic [31:0]        seed_q;
	logic [CNT_W-1:0]   cnt1_q, cnt2_q, n_q, idx_q, w_q;
	logic [CNT_W-1:0]   n_eff, cnt1_nx, cnt2_nx;
	logic [31:0]        r2_q, dvd_q;
	logic [REM_W-1:0]   rem_q;
	logic [4:0]         div_cnt_q;
	logic [ADDR_W-1:0]  cut_start_q, cut_end_q;
	logic [KEY_SPACE-1:0]  used_q;
	logic [GENE_SLOTS-1:0] filled_q;
	logic               cp_v_s1, em_v_s1, em_filled_s1, em_last_s1;
	logic [ADDR_W-1:0]  cp_addr_s1, em_addr_s1;

	logic               accept, wr1, wr2, job_go;
	logic               mt_done;
	logic [31:0]        mt_r1, mt_r2;
	logic [CNT_W-1:0]   div_d;
	logic [REM_W-1:0]   div_t, div_r;
	logic               div_last;
	logic               copy_end, idx_end, used_hit, w_full, w_taken;
	logic               ch_we;
	logic [ADDR_W-1:0]  ch_waddr, rd_addr;
	logic [GENE_W-1:0]  ch_wdata, p1_rdata, p2_rdata, ch_rdata;
	logic [GENE_W-1:0]  gene_in;

	always_comb begin
		if (gene_count_q == 7'd0) begin
			n_eff = CNT_W'(1);
		end else if (gene_count_q > 7'(GENE_SLOTS)) begin
			n_eff = SLOTS_C;
		end else begin
			n_eff = CNT_W'(gene_count_q);
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign wr1     = accept && !kind && (cnt1_q < n_eff);
	assign wr2     = accept && kind && (cnt2_q < n_eff);
	assign cnt1_nx = cnt1_q + CNT_W'(wr1);
	assign cnt2_nx = cnt2_q + CNT_W'(wr2);
	assign job_go  = accept && (cnt1_nx >= n_eff) && (cnt2_nx >= n_eff);
	assign gene_in = {gene_key, rotation_code};

	assign div_d    = (state_q == ST_DIV1) ? n_q : (n_q - CNT_W'(cut_start_q));
	assign div_t    = {rem_q[REM_W-2:0], dvd_q[31]};
	assign div_r    = (div_t >= REM_W'(div_d)) ? (div_t - REM_W'(div_d)) : div_t;
	assign div_last = (div_cnt_q == 5'd31);

	assign rd_addr  = idx_q[ADDR_W-1:0];
	assign copy_end = (idx_q == CNT_W'(cut_end_q));
	assign idx_end  = (idx_q == n_q - CNT_W'(1));
	assign used_hit = used_q[p2_rdata[GENE_W-1:ROT_W]];
	assign w_full   = (w_q >= n_q);
	assign w_taken  = filled_q[w_q[ADDR_W-1:0]];

	oce_twister u_twister (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (job_go),
		.seed   (seed_q),
		.done   (mt_done),
		.r1     (mt_r1),
		.r2     (mt_r2)
	);

	oce_ram #(.WIDTH(GENE_W), .DEPTH(GENE_SLOTS)) u_first_ram (
		.clk   (clk),
		.we    (wr1),
		.waddr (cnt1_q[ADDR_W-1:0]),
		.wdata (gene_in),
		.raddr (rd_addr),
		.rdata (p1_rdata)
	);

	oce_ram #(.WIDTH(GENE_W), .DEPTH(GENE_SLOTS)) u_second_ram (
		.clk   (clk),
		.we    (wr2),
		.waddr (cnt2_q[ADDR_W-1:0]),
		.wdata (gene_in),
		.raddr (rd_addr),
		.rdata (p2_rdata)
	);

	oce_ram #(.WIDTH(GENE_W), .DEPTH(GENE_SLOTS)) u_child_ram (
		.clk   (clk),
		.we    (ch_we),
		.waddr (ch_waddr),
		.wdata (ch_wdata),
		.raddr (rd_addr),
		.rdata (ch_rdata)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job_go) begin
					state_nx = ST_SEED;
				end
			end
			ST_SEED: begin
				if (mt_done) begin
					state_nx = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (div_last) begin
					state_nx = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (div_last) begin
					state_nx = ST_COPY;
				end
			end
			ST_COPY: begin
				if (copy_end) begin
					state_nx = ST_FILL_RD;
				end
			end
			ST_FILL_RD: state_nx = ST_FILL_CHK;
			ST_FILL_CHK: begin
				if (used_hit) begin
					state_nx = idx_end ? ST_EMIT : ST_FILL_RD;
				end else begin
					state_nx = ST_FILL_SEEK;
				end
			end
			ST_FILL_SEEK: begin
				if (w_full) begin
					state_nx = ST_EMIT;
				end else if (!w_taken) begin
					state_nx = idx_end ? ST_EMIT : ST_FILL_RD;
				end
			end
			ST_EMIT: begin
				if (idx_end) begin
					state_nx = ST_WRAP;
				end
			end
			ST_WRAP: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ch_we    = 1'b0;
		ch_waddr = cp_addr_s1;
		ch_wdata = p1_rdata;
		unique case (state_q)
			ST_FILL_SEEK: begin
				if (!w_full && !w_taken) begin
					ch_we    = 1'b1;
					ch_waddr = w_q[ADDR_W-1:0];
					ch_wdata = p2_rdata;
				end
			end
			default: begin
				ch_we = cp_v_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			gene_count_q <= GENE_COUNT_RST;
			seed_q       <= SEED_RST;
			cnt1_q       <= '0;
			cnt2_q       <= '0;
			used_q       <= '0;
			filled_q     <= '0;
			cp_v_s1      <= 1'b0;
			em_v_s1      <= 1'b0;
			div_cnt_q    <= '0;
			idx_q        <= '0;
			w_q          <= '0;
			cut_start_q  <= '0;
			cut_end_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GENE_COUNT: gene_count_q <= cfg_data[6:0];
					REG_SEED:       seed_q <= cfg_data;
					default: ;
				endcase
			end
			cp_v_s1 <= (state_q == ST_COPY);
			em_v_s1 <= (state_q == ST_EMIT);
			if (cp_v_s1) begin
				filled_q[cp_addr_s1]              <= 1'b1;
				used_q[p1_rdata[GENE_W-1:ROT_W]] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt1_q <= cnt1_nx;
					cnt2_q <= cnt2_nx;
				end
				ST_SEED: begin
					div_cnt_q <= '0;
				end
				ST_DIV1: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_last) begin
						cut_start_q <= ADDR_W'(div_r);
					end
				end
				ST_DIV2: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_last) begin
						cut_end_q <= cut_start_q + ADDR_W'(div_r);
						idx_q     <= CNT_W'(cut_start_q);
						w_q       <= '0;
					end
				end
				ST_COPY: begin
					idx_q <= copy_end ? '0 : idx_q + CNT_W'(1);
				end
				ST_FILL_RD: ;
				ST_FILL_CHK: begin
					if (used_hit) begin
						idx_q <= idx_end ? '0 : idx_q + CNT_W'(1);
					end
				end
				ST_FILL_SEEK: begin
					if (w_full) begin
						idx_q <= '0;
					end else if (w_taken) begin
						w_q <= w_q + CNT_W'(1);
					end else begin
						filled_q[w_q[ADDR_W-1:0]] <= 1'b1;
						w_q   <= w_q + CNT_W'(1);
						idx_q <= idx_end ? '0 : idx_q + CNT_W'(1);
					end
				end
				ST_EMIT: begin
					idx_q <= idx_q + CNT_W'(1);
				end
				ST_WRAP: begin
					used_q   <= '0;
					filled_q <= '0;
					cnt1_q   <= '0;
					cnt2_q   <= '0;
					idx_q    <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_go) begin
			n_q <= n_eff;
		end
		if (state_q == ST_SEED && mt_done) begin
			dvd_q <= mt_r1;
			r2_q  <= mt_r2;
			rem_q <= '0;
		end else if (state_q == ST_DIV1 && div_last) begin
			dvd_q <= r2_q;
			rem_q <= '0;
		end else if (state_q == ST_DIV1 || state_q == ST_DIV2) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= div_r;
		end
		cp_addr_s1   <= rd_addr;
		em_addr_s1   <= rd_addr;
		em_filled_s1 <= filled_q[rd_addr];
		em_last_s1   <= idx_end;
	end

	assign result_strobe  = em_v_s1;
	assign position       = POS_W'(em_addr_s1);
	assign slot_filled    = em_v_s1 && em_filled_s1;
	assign child_key      = slot_filled ? ch_rdata[GENE_W-1:ROT_W] : '0;
	assign child_rotation = slot_filled ? ch_rdata[ROT_W-1:0] : '0;
	assign last           = em_v_s1 && em_last_s1;

	`OCE_ASSERT_IMP(a_last_strobed, clk, arst_n, last, result_strobe)
	`OCE_ASSERT_IMP(a_result_busy, clk, arst_n, result_strobe, busy)
	`OCE_ASSERT_IMP(a_busy_falls_last, clk, arst_n, $fell(busy), $past(result_strobe && last))
	`OCE_ASSERT_IMP(a_cut_in_range, clk, arst_n, state_q == ST_COPY,
		(CNT_W'(cut_end_q) < n_q) && (cut_start_q <= cut_end_q))
	`OCE_ASSERT_NEXT(a_job_starts, clk, arst_n, job_go, state_q == ST_SEED)

endmodule

// File: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// Order crossover engine testbench
// Loads parent genes through the start/busy port, predicts every child slot
// of each crossover job with its own twister and fill walk, and compares
// each result beat with the oldest predicted slot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import oce_pkg::*;

	typedef struct packed {
		logic kind;
		key_t key;
		rot_t rot;
		logic hold;
		logic [2:0] gap;
	} gene_beat_t;

	typedef struct packed {
		pos_t pos;
		key_t key;
		rot_t rot;
		logic filled;
		logic last;
	} slot_t;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic kind = 1'b0;
	key_t gene_key = '0;
	rot_t rotation_code = '0;
	logic cfg_we = 1'b0;
	cfg_index_t cfg_index = REG_GENE_COUNT;
	cfg_data_t cfg_data = '0;
	logic result_strobe;
	pos_t position;
	key_t child_key;
	rot_t child_rotation;
	logic slot_filled;
	logic last;

	gene_beat_t pending_genes[$];
	slot_t child_slots[$];
	logic [GENE_W-1:0] parent_a[64];
	logic [GENE_W-1:0] parent_b[64];
	int loaded_a, loaded_b;
	logic [6:0] gene_count_reg;
	logic [31:0] seed_reg;
	int errors = 0;
	int idle_cycles = 0;
	int gap_left = 0;
	int queued_total = 0;

	order_crossover_engine_top uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] twister_draw(input logic [31:0] s, input int which);
		logic [31:0] mt[624];
		logic [31:0] p, y, v;
		begin
			mt[0] = s;
			for (int i = 1; i < 624; i++) begin
				p = mt[i-1];
				mt[i] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(i);
			end
			for (int i = 0; i <= which; i++) begin
				y = {mt[i][31], mt[i+1][30:0]};
				v = mt[i+397] ^ (y >> 1);
				if (y[0]) v = v ^ 32'h9908b0df;
				mt[i] = v;
			end
			y = mt[which];
			y = y ^ (y >> 11);
			y = y ^ ((y << 7) & 32'h9d2c5680);
			y = y ^ ((y << 15) & 32'hefc60000);
			y = y ^ (y >> 18);
			return y;
		end
	endfunction

	function automatic int active_count();
		if (gene_count_reg == 0) return 1;
		if (gene_count_reg > 64) return 64;
		return int'(gene_count_reg);
	endfunction

	task automatic build_child(input int n);
		logic [GENE_W-1:0] child[64];
		logic filled[64];
		logic used[64];
		logic [31:0] r1, r2;
		int cs, ce, w;
		slot_t s;
		begin
			for (int i = 0; i < 64; i++) begin
				filled[i] = 0;
				used[i] = 0;
				child[i] = '0;
			end
			r1 = twister_draw(seed_reg, 0);
			r2 = twister_draw(seed_reg, 1);
			cs = int'(r1 % n);
			ce = cs + int'(r2 % (n - cs));
			for (int i = cs; i <= ce; i++) begin
				child[i] = parent_a[i];
				filled[i] = 1;
				used[parent_a[i][GENE_W-1:ROT_W]] = 1;
			end
			w = 0;
			for (int i = 0; i < n; i++) begin
				if (!used[parent_b[i][GENE_W-1:ROT_W]]) begin
					while (w < n && filled[w]) w++;
					if (w >= n) break;
					child[w] = parent_b[i];
					filled[w] = 1;
					w++;
				end
			end
			for (int i = 0; i < n; i++) begin
				s.pos = pos_t'(i);
				s.key = filled[i] ? child[i][GENE_W-1:ROT_W] : '0;
				s.rot = filled[i] ? child[i][ROT_W-1:0] : '0;
				s.filled = filled[i];
				s.last = (i == n - 1);
				child_slots.insert(child_slots.size(), s);
			end
		end
	endtask

	task automatic predict_gene(input gene_beat_t g);
		int n;
		begin
			n = active_count();
			if (!g.kind) begin
				if (loaded_a < n) begin
					parent_a[loaded_a] = {g.key, g.rot};
					loaded_a = loaded_a + 1;
				end
			end else if (loaded_b < n) begin
				parent_b[loaded_b] = {g.key, g.rot};
				loaded_b = loaded_b + 1;
			end
			if (loaded_a >= n && loaded_b >= n) begin
				build_child(n);
				loaded_a = 0;
				loaded_b = 0;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_gene(pending_genes.pop_front());
				idle_cycles <= 0;
			end else if (result_strobe) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (start && !busy) begin
				if (pending_genes.size() == 0) begin
					start <= 1'b0;
				end else if (pending_genes[0].gap != 0 || pending_genes[0].hold) begin
					start <= 1'b0;
					gap_left <= pending_genes[0].gap;
				end else begin
					kind <= pending_genes[0].kind;
					gene_key <= pending_genes[0].key;
					rotation_code <= pending_genes[0].rot;
				end
			end else if (!start && pending_genes.size() != 0) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (!pending_genes[0].hold || child_slots.size() == 0) begin
					start <= 1'b1;
					kind <= pending_genes[0].kind;
					gene_key <= pending_genes[0].key;
					rotation_code <= pending_genes[0].rot;
				end
			end
			if (idle_cycles > WATCHDOG) begin
				$display("%0t watchdog expired", $time);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		slot_t e;
		if (arst_n && result_strobe) begin
			if (child_slots.size() == 0) begin
				$display("%0t unexpected slot pos=%0d", $time, position);
				errors++;
			end else begin
				e = child_slots.pop_front();
				if (e.pos !== position) begin
					$display("%0t position exp %0d got %0d", $time, e.pos, position);
					errors++;
				end
				if (e.key !== child_key) begin
					$display("%0t child_key exp %0d got %0d", $time, e.key, child_key);
					errors++;
				end
				if (e.rot !== child_rotation) begin
					$display("%0t child_rotation exp %h got %h", $time, e.rot,
						child_rotation);
					errors++;
				end
				if (e.filled !== slot_filled) begin
					$display("%0t slot_filled exp %b got %b", $time, e.filled,
						slot_filled);
					errors++;
				end
				if (e.last !== last) begin
					$display("%0t last exp %b got %b", $time, e.last, last);
					errors++;
				end
			end
		end
	end

	task automatic add_gene(input logic k, input key_t key, input rot_t rot, input logic hold);
		gene_beat_t g;
		begin
			g.kind = k;
			g.key = key;
			g.rot = rot;
			g.hold = hold;
			g.gap = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(0, 7));
			pending_genes.insert(pending_genes.size(), g);
			queued_total = queued_total + 1;
		end
	endtask

	task automatic drain();
		begin
			while (pending_genes.size() != 0 || start || child_slots.size() != 0)
				@(posedge clk);
			repeat (900) @(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
		begin
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
			cfg_we <= 1'b0;
			if (idx == REG_GENE_COUNT) gene_count_reg = val[6:0];
			else seed_reg = val;
		end
	endtask

	task automatic queue_job(input int n, input bit permute, input int extra);
		key_t keys[64];
		int j;
		key_t t;
		begin
			for (int p = 0; p < 2; p++) begin
				for (int i = 0; i < 64; i++) keys[i] = key_t'(i);
				for (int i = 63; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = keys[i];
					keys[i] = keys[j];
					keys[j] = t;
				end
				for (int i = 0; i < n; i++)
					add_gene(1'(p), permute ? keys[i] : key_t'($urandom),
						rot_t'($urandom), 1'b0);
			end
			for (int i = 0; i < extra; i++)
				add_gene(1'($urandom_range(0, 1)), key_t'($urandom), rot_t'($urandom),
					1'b0);
		end
	endtask

	initial begin
		int n;
		gene_count_reg = GENE_COUNT_RST;
		seed_reg = SEED_RST;
		loaded_a = 0;
		loaded_b = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_gene(1'b0, 6'd63, 16'hffff, 1'b0);
		add_gene(1'b1, 6'd0, 16'h0000, 1'b0);
		drain();
		write_reg(REG_GENE_COUNT, 32'd4);
		write_reg(REG_SEED, 32'd0);
		add_gene(1'b0, 6'd1, 16'h1234, 1'b0);
		add_gene(1'b0, 6'd2, 16'h5678, 1'b0);
		add_gene(1'b0, 6'd3, 16'h9abc, 1'b0);
		add_gene(1'b1, 6'd1, 16'h0001, 1'b0);
		add_gene(1'b1, 6'd1, 16'h0002, 1'b0);
		add_gene(1'b1, 6'd2, 16'h0003, 1'b0);
		add_gene(1'b0, 6'd0, 16'hdef0, 1'b0);
		add_gene(1'b1, 6'd63, 16'hffff, 1'b0);
		add_gene(1'b1, 6'd62, 16'haaaa, 1'b1);
		add_gene(1'b1, 6'd5, 16'h5555, 1'b0);
		drain();
		write_reg(REG_GENE_COUNT, 32'd0);
		write_reg(REG_SEED, 32'hffffffff);
		add_gene(1'b1, 6'd10, 16'h0f0f, 1'b0);
		add_gene(1'b0, 6'd20, 16'hf0f0, 1'b0);
		drain();
		write_reg(REG_GENE_COUNT, 32'd127);
		queue_job(64, 1, 0);
		drain();

		while (queued_total < 260) begin
			case ($urandom_range(0, 5))
				0: n = 64;
				1: n = $urandom_range(1, 3);
				default: n = $urandom_range(1, 12);
			endcase
			write_reg(REG_GENE_COUNT, 32'(n));
			write_reg(REG_SEED, $urandom);
			queue_job(n, $urandom_range(0, 3) != 0, $urandom_range(0, 2));
			if ($urandom_range(0, 3) == 0) begin
				pending_genes[pending_genes.size() - 1].hold = 1'b1;
				pending_genes[0].hold = 1'b1;
			end
			drain();
		end
		drain();
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/oce_pkg.sv
sv/oce_ram.sv
sv/oce_twister.sv
sv/order_crossover_engine_top.sv
tb/sv/tb.sv
